[hdl/assert_macros.svh]
// assertion macros for the rtl files, used by the colormap unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property must hold at every clock edge outside reset
`define SCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen outside reset
`define SCM_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`else

`define SCM_ASSERT(lbl, prop, msg)
`define SCM_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

[hdl/sclmap_pkg.sv]
// shared widths, codes and divider interface types for the colormap unit
package sclmap_pkg;

  // sample and color widths
  localparam int SAMPLE_BITS = 32;
  localparam int COLOR_BITS  = 8;
  localparam int IN_W        = 32;
  localparam int CH_W        = 8;

  // normalized fraction: q0.16 plus one integer bit for exactly one
  localparam int FRAC_BITS = 16;
  localparam int T_W       = FRAC_BITS + 1;

  // range differences are non-negative and need one extra bit
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int CNT_W  = $clog2(FRAC_BITS);

  // request kinds carried in tuser
  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_SCAN  = 2'd1,
    REQ_MAP   = 2'd2
  } req_e;

  // color modes of the configuration register
  typedef enum logic [1:0] {
    MODE_GREY    = 2'd0,
    MODE_BLEND   = 2'd1,
    MODE_RAINBOW = 2'd2
  } mode_e;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_EMIT = 2'd2
  } state_e;

  // divider request and response
  typedef struct packed {
    logic              start;
    logic [DIFF_W-1:0] num;
    logic [DIFF_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic [FRAC_BITS-1:0] quot;
  } div_rsp_t;

endpackage

[hdl/sclmap_div.sv]
// iterative restoring divider giving a q0.16 fraction num/den with num < den
module sclmap_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sclmap_pkg::div_req_t req_i,
  output sclmap_pkg::div_rsp_t rsp_o
);
  import sclmap_pkg::*;

  logic [DIFF_W-1:0]    rem_q, rem_d;
  logic [DIFF_W-1:0]    den_q;
  logic [FRAC_BITS-1:0] quot_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 busy_q, done_q;
  logic [DIFF_W:0]      shifted;
  logic [DIFF_W:0]      diff;
  logic                 ge;

  // one quotient bit per cycle: shift, compare, subtract
  assign shifted = {rem_q, 1'b0};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = shifted >= {1'b0, den_q};
  assign rem_d   = ge ? diff[DIFF_W-1:0] : shifted[DIFF_W-1:0];

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FRAC_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FRAC_BITS-2:0], ge};
    end
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[hdl/scalar_colormap_unit.sv]
// scalar to color mapper: min/max range tracking and three color modes
// clear and scan beats act on the tracked range and give no result
// a map beat below the top of a proper range runs through the 16-step restoring
// divider first; top-of-range, out-of-range or improper-range maps go straight to emit
// the next beat is taken once the map result sits in the output register
// async active-low reset: range empty (low at max, high at min), greyscale mode
module scalar_colormap_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration write channel: color mode
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_data_i,
  // input stream
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [sclmap_pkg::IN_W-1:0] s_axis_tdata_i,   // [31:0] sample
  input  logic [1:0]                  s_axis_tuser_i,   // [1:0] req_type
  // output stream
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [23:0]                 m_axis_tdata_o,   // [7:0] red, [15:8] green,
                                                        // [23:16] blue
  output logic                        m_axis_tuser_o    // [0] degenerate
);
  import sclmap_pkg::*;

  localparam int PROD_W     = T_W + 16;
  localparam int FULL_SCALE = (1 << COLOR_BITS) - 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1 << FRAC_BITS);

  // hue sectors of 60 degrees
  localparam logic [2:0] SEC_RED_YEL  = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN  = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN  = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU  = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG  = 3'd4;

  // q1.16 fraction to a channel value
  function automatic logic [CH_W-1:0] channel(input logic [T_W-1:0] c);
    logic [PROD_W-1:0] p;
    p = PROD_W'(c) * PROD_W'(FULL_SCALE);
    return p[FRAC_BITS +: CH_W];
  endfunction

  state_e                        state_q, state_d;
  logic [1:0]                    mode_q;
  logic signed [SAMPLE_BITS-1:0] low_q, high_q;
  logic [T_W-1:0]                t_q, t_d;
  logic                          deg_q, deg_d;
  logic                          out_valid_q;
  logic [CH_W-1:0]               red_q, green_q, blue_q;
  logic                          out_deg_q;
  logic                          out_load;

  logic                          s_hs;
  req_e                          req;
  logic signed [SAMPLE_BITS-1:0] smp;
  logic signed [DIFF_W-1:0]      smp_x, low_x, high_x;
  logic                          lt_lo, lt_hi, rng_ok, at_top;

  logic                          div_start;
  div_req_t                      div_req;
  div_rsp_t                      div_rsp;

  // input decode and range compares
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_hs   = s_axis_tvalid_i && s_axis_tready_o;
  assign req    = req_e'(s_axis_tuser_i);
  assign smp    = SAMPLE_BITS'(signed'(s_axis_tdata_i));
  assign smp_x  = DIFF_W'(smp);
  assign low_x  = DIFF_W'(low_q);
  assign high_x = DIFF_W'(high_q);
  assign lt_lo  = smp < low_q;
  assign lt_hi  = high_q < smp;
  assign rng_ok = low_q < high_q;
  assign at_top = smp == high_q;

  assign div_req.start = div_start;
  assign div_req.num   = DIFF_W'(smp_x - low_x);
  assign div_req.den   = DIFF_W'(high_x - low_x);

  sclmap_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequencer next state and controls
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    t_d       = t_q;
    deg_d     = deg_q;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (s_hs && req == REQ_MAP) begin
          if (!rng_ok || lt_lo || lt_hi) begin
            deg_d   = 1'b1;
            state_d = ST_EMIT;
          end else if (at_top) begin
            deg_d   = 1'b0;
            t_d     = T_ONE;
            state_d = ST_EMIT;
          end else begin
            deg_d     = 1'b0;
            div_start = 1'b1;
            state_d   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          t_d     = {1'b0, div_rsp.quot};
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // fraction and degenerate flag of the item at work
  always_ff @(posedge clk_i) begin
    t_q   <= t_d;
    deg_q <= deg_d;
  end

  // configuration register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_GREY;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  // tracked range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q  <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      high_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else if (s_hs) begin
      case (req)
        REQ_CLEAR: begin
          low_q  <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
          high_q <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        REQ_SCAN: begin
          if (lt_lo) begin
            low_q <= smp;
          end
          if (lt_hi) begin
            high_q <= smp;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // color formation from the fraction
  logic [T_W-1:0]   t_inv;
  logic [T_W+1:0]   hue;
  logic [2:0]       sector;
  logic [T_W-1:0]   x_frac;
  logic [T_W-1:0]   sel_frac;
  logic [CH_W-1:0]  ch_t, ch_x, ch_full;
  logic [CH_W-1:0]  red_d, green_d, blue_d;

  assign t_inv    = T_ONE - t_q;
  assign hue      = {t_inv, 2'b00};
  assign sector   = hue[T_W+1:FRAC_BITS];
  assign x_frac   = sector[0] ? T_ONE - T_W'(hue[FRAC_BITS-1:0])
                              : T_W'(hue[FRAC_BITS-1:0]);
  assign sel_frac = (mode_e'(mode_q) == MODE_BLEND) ? t_inv : x_frac;
  assign ch_t     = channel(t_q);
  assign ch_x     = channel(sel_frac);
  assign ch_full  = channel(T_ONE);

  always_comb begin
    red_d   = '0;
    green_d = '0;
    blue_d  = '0;
    if (!deg_q) begin
      case (mode_e'(mode_q))
        MODE_BLEND: begin
          red_d  = ch_t;
          blue_d = ch_x;
        end
        MODE_RAINBOW: begin
          case (sector)
            SEC_RED_YEL: begin
              red_d   = ch_full;
              green_d = ch_x;
            end
            SEC_YEL_GRN: begin
              red_d   = ch_x;
              green_d = ch_full;
            end
            SEC_GRN_CYN: begin
              green_d = ch_full;
              blue_d  = ch_x;
            end
            SEC_CYN_BLU: begin
              green_d = ch_x;
              blue_d  = ch_full;
            end
            SEC_BLU_MAG: begin
              red_d  = ch_x;
              blue_d = ch_full;
            end
            default: begin
              red_d  = ch_full;
              blue_d = ch_x;
            end
          endcase
        end
        default: begin
          red_d   = ch_t;
          green_d = ch_t;
          blue_d  = ch_t;
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      red_q     <= red_d;
      green_q   <= green_d;
      blue_q    <= blue_d;
      out_deg_q <= deg_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {blue_q, green_q, red_q};
  assign m_axis_tuser_o  = out_deg_q;

  // checks
`include "assert_macros.svh"

  `SCM_ASSERT(a_deg_black, m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == '0, "degenerate beat with nonzero color")
  `SCM_ASSERT(a_div_in_seq, div_rsp.done |-> state_q == ST_DIV, "divider finished outside divide state")
  `SCM_ASSERT(a_scan_order, s_hs && req == REQ_SCAN |=> low_q <= high_q, "range bounds out of order after scan")
  `SCM_ASSERT_NEVER(a_start_busy, div_req.start && div_rsp.busy, "divider restarted while busy")

endmodule
